[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/poc_pkg.sv]
// ----------------------------------------------------------------------------
// poc_pkg
// Shared constants and types of the pattern occurrence counter.
// ----------------------------------------------------------------------------
`default_nettype none
package poc_pkg;
	localparam int MAX_PATTERN_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int SLOTS           = 16;
	localparam int TOTAL_WIDTH     = 32;
	localparam int LEN_WIDTH       = 5;
	localparam int IDX_WIDTH       = 4;

	localparam logic [1:0] MODE_PLAIN       = 2'd0;
	localparam logic [1:0] MODE_NEW_SEQ     = 2'd1;
	localparam logic [1:0] MODE_CLEAR_ALL   = 2'd2;
	localparam logic [1:0] MODE_CLEAR_ALL_X = 2'd3;

	localparam logic [1:0] REG_CHARS_LOW   = 2'd0;
	localparam logic [1:0] REG_CHARS_HIGH  = 2'd1;
	localparam logic [1:0] REG_LENGTH      = 2'd2;
	localparam logic [1:0] REG_MIN_SUPPORT = 2'd3;

	localparam logic [LEN_WIDTH-1:0] LEN_MIN   = 5'd2;
	localparam logic [LEN_WIDTH-1:0] LEN_RESET = 5'd2;
	localparam logic [TOTAL_WIDTH-1:0] MIN_SUPPORT_RESET = 32'd1;

	typedef struct packed {
		logic       upd;
		logic       clear;
		logic [7:0] symbol;
	} cell_ctrl_t;
endpackage
`default_nettype wire

[src/poc_cell.sv]
// ----------------------------------------------------------------------------
// poc_cell
// One pattern position: counter, character match and priority hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module poc_cell #(
	parameter int COUNT_WIDTH = poc_pkg::COUNT_WIDTH_DEF,
	parameter bit FIRST       = 1'b0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  poc_pkg::cell_ctrl_t     ctrl,
	input  wire                     active,
	input  wire  [7:0]              pchar,
	input  wire  [COUNT_WIDTH-1:0]  prev_eff,
	input  wire                     taken_in,
	output logic [COUNT_WIDTH-1:0]  eff,
	output logic                    taken_out,
	output logic                    win
);
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   cand;
	logic [COUNT_WIDTH-1:0] count_next;

	always_comb begin
		eff = ctrl.clear ? '0 : count_q;
		cand = active && (pchar == ctrl.symbol) && (FIRST || (eff < prev_eff));
		win = cand && !taken_in;
		taken_out = taken_in || cand;
		count_next = (win && (eff != '1)) ? eff + 1'b1 : eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.upd) begin
			count_q <= count_next;
		end
	end
endmodule
`default_nettype wire

[src/pattern_occurrence_counter_core.sv]
// ----------------------------------------------------------------------------
// pattern_occurrence_counter_core
// Counts pattern occurrences in a symbol stream with one cell per position.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | s_tdata symbol, s_tuser mode
// m_      | out       | m_tvalid/m_tready  | m_tdata hit, index, done, total, frequent
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while s_tready is high; the result is registered on
// acceptance. All cells resolve the symbol in the acceptance cycle through the
// priority chain that runs from the last position down to position zero.
// Reset clears counters, total and configuration (length 2, min support 1).
// s_tready drops only while a result waits and m_tready is low.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pattern_occurrence_counter_core #(
	parameter int MAX_PATTERN = poc_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH = poc_pkg::COUNT_WIDTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,  // [7:0] symbol
	input  wire  [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // [0] position_hit, [4:1] hit_index,
	                              // [5] occurrence_done, [37:6] total_occurrences,
	                              // [38] frequent, [39] zero
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [63:0] cfg_data
);
	localparam int TW = poc_pkg::TOTAL_WIDTH;
	localparam int LW = poc_pkg::LEN_WIDTH;
	localparam int IW = poc_pkg::IDX_WIDTH;

	logic [63:0]   chars_low_q;
	logic [63:0]   chars_high_q;
	logic [LW-1:0] length_q;
	logic [TW-1:0] min_support_q;
	logic [TW-1:0] total_q;

	logic          out_valid_q;
	logic          hit_q;
	logic [IW-1:0] index_q;
	logic          done_q;
	logic [TW-1:0] total_out_q;
	logic          frequent_q;

	logic                   s_acc;
	logic [LW-1:0]          len_used;
	logic [127:0]           chars_all;
	poc_pkg::cell_ctrl_t    ctrl;
	logic                   clear_total;
	logic [MAX_PATTERN:0]   taken;
	logic [MAX_PATTERN-1:0] win;
	logic [COUNT_WIDTH-1:0] eff [MAX_PATTERN];
	logic [IW-1:0]          index_c;
	logic                   hit_c;
	logic                   done_c;
	logic [TW-1:0]          total_base;
	logic [TW-1:0]          total_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign s_acc     = s_tvalid && s_tready;
	assign chars_all = {chars_high_q, chars_low_q};
	assign taken[MAX_PATTERN] = 1'b0;

	always_comb begin
		if (length_q < poc_pkg::LEN_MIN) begin
			len_used = poc_pkg::LEN_MIN;
		end else if (length_q > LW'(MAX_PATTERN)) begin
			len_used = LW'(MAX_PATTERN);
		end else begin
			len_used = length_q;
		end
		ctrl.upd    = s_acc;
		ctrl.clear  = (s_tuser != poc_pkg::MODE_PLAIN);
		ctrl.symbol = s_tdata;
		clear_total = (s_tuser == poc_pkg::MODE_CLEAR_ALL) ||
			(s_tuser == poc_pkg::MODE_CLEAR_ALL_X);
	end

	for (genvar m = 0; m < MAX_PATTERN; m++) begin : g_cell
		poc_cell #(
			.COUNT_WIDTH(COUNT_WIDTH),
			.FIRST      (m == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.active   (LW'(m) < len_used),
			.pchar    (chars_all[8*m +: 8]),
			.prev_eff ((m == 0) ? '0 : eff[(m == 0) ? 0 : m-1]),
			.taken_in (taken[m+1]),
			.eff      (eff[m]),
			.taken_out(taken[m]),
			.win      (win[m])
		);
	end

	always_comb begin
		index_c = '0;
		done_c  = 1'b0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (win[i]) begin
				index_c = index_c | IW'(i);
			end
			if (win[i] && (LW'(i) == (len_used - 1'b1))) begin
				done_c = 1'b1;
			end
		end
		hit_c      = |win;
		total_base = clear_total ? '0 : total_q;
		total_next = (done_c && (total_base != '1)) ? total_base + 1'b1 : total_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q   <= '0;
			chars_high_q  <= '0;
			length_q      <= poc_pkg::LEN_RESET;
			min_support_q <= poc_pkg::MIN_SUPPORT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				poc_pkg::REG_CHARS_LOW:   chars_low_q   <= cfg_data;
				poc_pkg::REG_CHARS_HIGH:  chars_high_q  <= cfg_data;
				poc_pkg::REG_LENGTH:      length_q      <= cfg_data[LW-1:0];
				poc_pkg::REG_MIN_SUPPORT: min_support_q <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				total_q     <= total_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			hit_q       <= hit_c;
			index_q     <= index_c;
			done_q      <= done_c;
			total_out_q <= total_next;
			frequent_q  <= (total_next >= min_support_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, frequent_q, total_out_q, done_q, index_q, hit_q};

	`ASSERT_ALWAYS(a_win_onehot, clk, arst_n, $onehot0(win))
	`ASSERT_ALWAYS(a_done_needs_hit, clk, arst_n, !out_valid_q || !done_q || hit_q)
	`ASSERT_NEXT(a_accept_fills, clk, arst_n, s_acc, out_valid_q)
	`ASSERT_NEXT(a_total_cleared, clk, arst_n, s_acc && clear_total && !done_c, total_q == '0)
	`ASSERT_NEXT(a_total_tracks, clk, arst_n, s_acc, total_out_q == total_q)
endmodule
`default_nettype wire

[tb/tb_pattern_occurrence_counter_core.sv]
// ----------------------------------------------------------------------------
// tb_pattern_occurrence_counter_core
// Self-checking bench for the pattern occurrence counter. Symbols stream in
// with random gaps while results drain with random stalls, each of them off in
// some phases. A tracker mirrors the position counters and the running total,
// and compares every result field by field. Configuration changes only
// between phases, once every result is back. A run of the first pattern
// character drives the first position counter up.
// ----------------------------------------------------------------------------
module tb_pattern_occurrence_counter_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;
	localparam int IW         = poc_pkg::IDX_WIDTH;
	localparam int LW         = poc_pkg::LEN_WIDTH;

	typedef struct packed {
		logic                            pad;
		logic                            frequent;
		logic [poc_pkg::TOTAL_WIDTH-1:0] total;
		logic                            done;
		logic [poc_pkg::IDX_WIDTH-1:0]   index;
		logic                            hit;
	} occ_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic [1:0]  s_tuser   = poc_pkg::MODE_PLAIN;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = poc_pkg::REG_CHARS_LOW;
	logic [63:0] cfg_data  = '0;

	logic        send_gaps   = 1'b1;
	logic        recv_stalls = 1'b1;
	logic [63:0] cur_low     = '0;
	logic [63:0] cur_high    = '0;
	int          cur_used    = 2;
	int          idle_cycles = 0;

	function automatic int used_length(logic [poc_pkg::LEN_WIDTH-1:0] len);
		if (len < poc_pkg::LEN_MIN)
			return int'(poc_pkg::LEN_MIN);
		if (len > poc_pkg::MAX_PATTERN_DEF)
			return poc_pkg::MAX_PATTERN_DEF;
		return int'(len);
	endfunction

	function automatic logic [7:0] pattern_char(logic [63:0] low, logic [63:0] high, int i);
		if (i < 8)
			return low[i*8 +: 8];
		return high[(i-8)*8 +: 8];
	endfunction

	class count_tracker;
		logic [63:0]                         chars_low;
		logic [63:0]                         chars_high;
		logic [poc_pkg::LEN_WIDTH-1:0]       len_reg;
		logic [poc_pkg::TOTAL_WIDTH-1:0]     min_sup;
		logic [poc_pkg::COUNT_WIDTH_DEF-1:0] pos_count [poc_pkg::SLOTS];
		logic [poc_pkg::TOTAL_WIDTH-1:0]     total;
		occ_result_t                         pending_results [$];
		int                                  errors;

		function new();
			chars_low  = '0;
			chars_high = '0;
			len_reg    = poc_pkg::LEN_RESET;
			min_sup    = poc_pkg::MIN_SUPPORT_RESET;
			total      = '0;
			errors     = 0;
			foreach (pos_count[i])
				pos_count[i] = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				poc_pkg::REG_CHARS_LOW:   chars_low  = data;
				poc_pkg::REG_CHARS_HIGH:  chars_high = data;
				poc_pkg::REG_LENGTH:      len_reg    = data[poc_pkg::LEN_WIDTH-1:0];
				poc_pkg::REG_MIN_SUPPORT: min_sup    = data[poc_pkg::TOTAL_WIDTH-1:0];
			endcase
		endfunction

		function void take_symbol(logic [1:0] mode, logic [7:0] sym);
			int          used;
			int          m;
			occ_result_t r;
			used = used_length(len_reg);
			r    = '0;
			if (mode != poc_pkg::MODE_PLAIN)
				foreach (pos_count[i])
					pos_count[i] = '0;
			if (mode == poc_pkg::MODE_CLEAR_ALL || mode == poc_pkg::MODE_CLEAR_ALL_X)
				total = '0;
			for (m = used - 1; m > 0 && !r.hit; m--) begin
				if (pattern_char(chars_low, chars_high, m) == sym &&
				    pos_count[m] < pos_count[m-1]) begin
					pos_count[m]++;
					r.index = IW'(m);
					r.hit   = 1'b1;
				end
			end
			if (!r.hit && pattern_char(chars_low, chars_high, 0) == sym) begin
				if (pos_count[0] != '1)
					pos_count[0]++;
				r.index = '0;
				r.hit   = 1'b1;
			end
			if (r.hit && r.index == used - 1) begin
				r.done = 1'b1;
				if (total != '1)
					total++;
			end
			r.total    = total;
			r.frequent = total >= min_sup;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_result(logic [39:0] raw);
			occ_result_t got;
			occ_result_t want;
			got = raw;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, raw);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("position_hit", 32'(want.hit), 32'(got.hit));
			compare_field("hit_index", 32'(want.index), 32'(got.index));
			compare_field("occurrence_done", 32'(want.done), 32'(got.done));
			compare_field("total_occurrences", want.total, got.total);
			compare_field("frequent", 32'(want.frequent), 32'(got.frequent));
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	count_tracker tracker = new();

	pattern_occurrence_counter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog expired", $time);
				$display("CHECKS FAILED");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = recv_stalls ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			tracker.match_result(m_tdata);
		end
	end

	task automatic send_symbol(logic [1:0] mode, logic [7:0] sym);
		int gap;
		gap = send_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tuser  <= mode;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		tracker.take_symbol(mode, sym);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		tracker.write_reg(idx, data);
	endtask

	task automatic write_config(logic [63:0] low, logic [63:0] high,
	                            logic [63:0] len_word, logic [63:0] sup_word);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		write_reg(poc_pkg::REG_CHARS_LOW, low);
		write_reg(poc_pkg::REG_CHARS_HIGH, high);
		write_reg(poc_pkg::REG_LENGTH, len_word);
		write_reg(poc_pkg::REG_MIN_SUPPORT, sup_word);
		cfg_valid <= 1'b0;
		cur_low  = low;
		cur_high = high;
		cur_used = used_length(len_word[poc_pkg::LEN_WIDTH-1:0]);
	endtask

	task automatic run_random(int count);
		int         k;
		int         pick;
		int         walk;
		logic [1:0] mode;
		logic [7:0] sym;
		walk = 0;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 93)
				mode = poc_pkg::MODE_PLAIN;
			else if (pick < 96)
				mode = poc_pkg::MODE_NEW_SEQ;
			else if (pick < 98)
				mode = poc_pkg::MODE_CLEAR_ALL;
			else
				mode = poc_pkg::MODE_CLEAR_ALL_X;
			if (mode != poc_pkg::MODE_PLAIN)
				walk = 0;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				sym  = pattern_char(cur_low, cur_high, walk);
				walk = (walk + 1) % cur_used;
			end else if (pick < 90)
				sym = pattern_char(cur_low, cur_high, $urandom_range(0, cur_used - 1));
			else
				sym = 8'($urandom_range(0, 255));
			send_symbol(mode, sym);
		end
	endtask

	initial begin
		logic [63:0]                   low;
		logic [63:0]                   high;
		logic [63:0]                   rnd;
		logic [poc_pkg::LEN_WIDTH-1:0] len;
		logic [31:0]                   sup;
		int                            phase;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: all-zero pattern of length two
		send_symbol(poc_pkg::MODE_PLAIN, 8'h00);
		send_symbol(poc_pkg::MODE_PLAIN, 8'h00);
		send_symbol(poc_pkg::MODE_PLAIN, 8'hFF);
		send_symbol(poc_pkg::MODE_PLAIN, 8'h00);
		send_symbol(poc_pkg::MODE_NEW_SEQ, 8'h00);
		send_symbol(poc_pkg::MODE_CLEAR_ALL, 8'h00);
		send_symbol(poc_pkg::MODE_CLEAR_ALL_X, 8'hFF);
		send_symbol(poc_pkg::MODE_PLAIN, 8'h55);
		send_symbol(poc_pkg::MODE_PLAIN, 8'hAA);
		send_symbol(poc_pkg::MODE_CLEAR_ALL_X, 8'h00);

		// all-ones pattern, length below minimum, zero support
		write_config('1, '1, 64'hFFFF_FFFF_FFFF_FFE1, 64'hFFFF_FFFF_0000_0000);
		send_symbol(poc_pkg::MODE_CLEAR_ALL, 8'h00);
		send_symbol(poc_pkg::MODE_PLAIN, 8'hFF);
		send_symbol(poc_pkg::MODE_PLAIN, 8'hFF);
		send_symbol(poc_pkg::MODE_PLAIN, 8'hFF);
		send_symbol(poc_pkg::MODE_NEW_SEQ, 8'hFF);
		send_symbol(poc_pkg::MODE_PLAIN, 8'h7F);

		// advance the first position counter
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		write_config(64'h0000_0000_0000_A55A, '0, 64'd2, 64'hFFFF_FFFF);
		send_symbol(poc_pkg::MODE_CLEAR_ALL, 8'h5A);
		repeat (30) send_symbol(poc_pkg::MODE_PLAIN, 8'h5A);
		repeat (3) send_symbol(poc_pkg::MODE_PLAIN, 8'hA5);

		for (phase = 0; phase < 8; phase++) begin
			send_gaps   = (phase % 4) != 1;
			recv_stalls = (phase % 4) != 2;
			low  = {$urandom, $urandom};
			high = {$urandom, $urandom};
			if (phase == 6) begin
				low  = '0;
				high = '0;
			end
			if (phase == 7) begin
				low  = '1;
				high = '1;
			end
			case (phase)
				0: begin
					len = 5'd16;
					sup = 32'd0;
				end
				1: begin
					len = 5'd31;
					sup = 32'hFFFF_FFFF;
				end
				2: begin
					len = 5'd2;
					sup = $urandom_range(1, 10);
				end
				3: begin
					len = 5'd0;
					sup = 32'd3;
				end
				4: begin
					len = LW'($urandom_range(3, 15));
					sup = $urandom_range(1, 30);
				end
				5: begin
					len = LW'($urandom_range(17, 30));
					sup = $urandom;
				end
				6: begin
					len = LW'($urandom_range(2, 16));
					sup = 32'd5;
				end
				default: begin
					len = 5'd16;
					sup = 32'd1;
				end
			endcase
			rnd = {$urandom, $urandom};
			write_config(low, high, {rnd[63:poc_pkg::LEN_WIDTH], len}, {rnd[31:0], sup});
			run_random(190);
		end

		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
